### design/mpgd_pkg.sv
// ----------------------------------------------------------------------------
// mpgd_pkg
// Shared types and codes for the Morse press/gap decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mpgd_pkg;

  localparam int unsigned DUR_W   = 23;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned GLYPH_W = 5;

  typedef logic [3:0] mark_bits_t;
  typedef logic [2:0] mark_count_t;
  typedef logic [GLYPH_W-1:0] glyph_t;

  localparam mark_count_t MAX_MARKS = 3'd4;
  localparam glyph_t GLYPH_ERROR = 5'd27;

  typedef enum logic [1:0] {
    OUTCOME_LETTER    = 2'd0,
    OUTCOME_LONG      = 2'd1,
    OUTCOME_OVERFLOW  = 2'd2,
    OUTCOME_INVALID   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_DOT_LIMIT  = 2'd0,
    CFG_DASH_LIMIT = 2'd1,
    CFG_GAP_LIMIT  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    glyph_t   glyph;
    outcome_t outcome;
  } result_t;

endpackage

`default_nettype wire

### design/mpgd_glyph_lut.sv
// ----------------------------------------------------------------------------
// mpgd_glyph_lut
// Maps one to four held marks (1 = dash, earliest mark highest) to a display
// code: 1-26 for A-Z, error code for invalid or empty patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module mpgd_glyph_lut (
  input  mpgd_pkg::mark_bits_t  mark_bits,
  input  mpgd_pkg::mark_count_t mark_count,
  output mpgd_pkg::glyph_t      glyph
);

  always_comb begin
    glyph = mpgd_pkg::GLYPH_ERROR;
    case (mark_count)
      3'd1: begin
        case (mark_bits[0])
          1'b0:    glyph = 5'd5;
          default: glyph = 5'd20;
        endcase
      end
      3'd2: begin
        case (mark_bits[1:0])
          2'd0:    glyph = 5'd9;
          2'd1:    glyph = 5'd1;
          2'd2:    glyph = 5'd14;
          default: glyph = 5'd13;
        endcase
      end
      3'd3: begin
        case (mark_bits[2:0])
          3'd0:    glyph = 5'd19;
          3'd1:    glyph = 5'd21;
          3'd2:    glyph = 5'd18;
          3'd3:    glyph = 5'd23;
          3'd4:    glyph = 5'd4;
          3'd5:    glyph = 5'd11;
          3'd6:    glyph = 5'd7;
          default: glyph = 5'd15;
        endcase
      end
      3'd4: begin
        case (mark_bits)
          4'd0:    glyph = 5'd8;
          4'd1:    glyph = 5'd22;
          4'd2:    glyph = 5'd6;
          4'd4:    glyph = 5'd12;
          4'd6:    glyph = 5'd16;
          4'd7:    glyph = 5'd10;
          4'd8:    glyph = 5'd2;
          4'd9:    glyph = 5'd24;
          4'd10:   glyph = 5'd3;
          4'd11:   glyph = 5'd25;
          4'd12:   glyph = 5'd26;
          4'd13:   glyph = 5'd17;
          default: glyph = mpgd_pkg::GLYPH_ERROR;
        endcase
      end
      default: glyph = mpgd_pkg::GLYPH_ERROR;
    endcase
  end

endmodule

`default_nettype wire

### design/morse_press_gap_decoder.sv
// ----------------------------------------------------------------------------
// morse_press_gap_decoder
// Classifies timed key presses into dots and dashes, decodes held marks into
// a letter code on a long release gap, and reports errors.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: duration_ms  tuser: event_kind
//  m_*      out  m_tvalid/m_tready  tdata: glyph_code   tuser: outcome
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
//  One item per cycle while s_tready is high: each transfer is classified and
//  the mark state updated in the cycle it is taken; a result is registered.
//  A two-entry output buffer (output register plus skid register) lets input
//  transfers continue while a result waits; s_tready drops only when both
//  entries are full. rst clears the limits to their defaults, the held marks
//  and both output entries.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_press_gap_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [22:0] duration_ms
  input  wire logic        s_tuser,   // [0] event_kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [4:0] glyph_code
  output logic [1:0]       m_tuser,   // [1:0] outcome
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [mpgd_pkg::LIMIT_W-1:0] dot_limit;
  logic [mpgd_pkg::LIMIT_W-1:0] dash_limit;
  logic [mpgd_pkg::LIMIT_W-1:0] gap_limit;

  mpgd_pkg::mark_bits_t  mark_bits, mark_bits_next;
  mpgd_pkg::mark_count_t mark_count, mark_count_next;

  mpgd_pkg::result_t out_res, skid_res, res_next;
  logic              out_valid, skid_valid, has_res;

  logic [mpgd_pkg::DUR_W-1:0] dur;
  logic                       is_gap, below_dot, below_dash, gap_long;
  logic                       accept, pop;
  mpgd_pkg::glyph_t           glyph;

  mpgd_glyph_lut u_lut (
    .mark_bits  (mark_bits),
    .mark_count (mark_count),
    .glyph      (glyph)
  );

  assign dur        = s_tdata[mpgd_pkg::DUR_W-1:0];
  assign is_gap     = s_tuser;
  assign below_dot  = dur < {7'd0, dot_limit};
  assign below_dash = dur < {7'd0, dash_limit};
  assign gap_long   = dur >= {7'd0, gap_limit};

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;

  always_comb begin
    mark_bits_next  = mark_bits;
    mark_count_next = mark_count;
    has_res         = 1'b0;
    res_next.glyph   = mpgd_pkg::GLYPH_ERROR;
    res_next.outcome = mpgd_pkg::OUTCOME_LETTER;
    if (!is_gap) begin
      if (dur != '0) begin
        if (!below_dot && !below_dash) begin
          has_res          = 1'b1;
          res_next.outcome = mpgd_pkg::OUTCOME_LONG;
        end else if (mark_count >= mpgd_pkg::MAX_MARKS) begin
          has_res          = 1'b1;
          res_next.outcome = mpgd_pkg::OUTCOME_OVERFLOW;
          mark_bits_next   = '0;
          mark_count_next  = '0;
        end else begin
          mark_bits_next  = {mark_bits[2:0], !below_dot};
          mark_count_next = mark_count + 3'd1;
        end
      end
    end else if (gap_long && (mark_count != '0)) begin
      has_res          = 1'b1;
      res_next.glyph   = glyph;
      res_next.outcome = (glyph == mpgd_pkg::GLYPH_ERROR) ?
                         mpgd_pkg::OUTCOME_INVALID : mpgd_pkg::OUTCOME_LETTER;
      mark_bits_next   = '0;
      mark_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_limit  <= 16'd250;
      dash_limit <= 16'd700;
      gap_limit  <= 16'd400;
    end else if (cfg_we) begin
      case (mpgd_pkg::cfg_index_t'(cfg_index))
        mpgd_pkg::CFG_DOT_LIMIT:  dot_limit  <= cfg_data;
        mpgd_pkg::CFG_DASH_LIMIT: dash_limit <= cfg_data;
        mpgd_pkg::CFG_GAP_LIMIT:  gap_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_bits  <= '0;
      mark_count <= '0;
    end else if (accept) begin
      mark_bits  <= mark_bits_next;
      mark_count <= mark_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (accept && has_res) begin
      if (!out_valid || pop) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res.glyph};
  assign m_tuser  = out_res.outcome;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timed key presses and release gaps into the Morse decoder under a
// series of dot, dash and gap limits, predicts each letter code or error in
// step with every accepted transfer, and checks the result stream field by
// field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic KEY_PRESS = 1'b0;
  localparam logic KEY_GAP   = 1'b1;
  localparam int unsigned DUR_MAX = 4294967;
  localparam int unsigned PHASE_EVENTS = 90;
  // Morse tree in heap order: node (1 << count) | marks, first char is node 2
  localparam logic [8*30-1:0] MORSE_TREE = "ETIANMSURWDKGOHVF?L?PJBXCYZQ??";

  typedef struct {
    logic                       kind;
    logic [mpgd_pkg::DUR_W-1:0] dur;
  } key_event_t;

  typedef struct {
    bit                hit;
    mpgd_pkg::result_t res;
  } prediction_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [22:0] duration_ms
  logic        s_tuser = 1'b0; // [0] event_kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [4:0] glyph_code
  logic [1:0]  m_tuser;        // [1:0] outcome
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  morse_press_gap_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  key_event_t        key_events[$];
  mpgd_pkg::result_t decoded_due[$];

  logic [mpgd_pkg::LIMIT_W-1:0] dot_lim  = 16'd250;
  logic [mpgd_pkg::LIMIT_W-1:0] dash_lim = 16'd700;
  logic [mpgd_pkg::LIMIT_W-1:0] gap_lim  = 16'd400;
  mpgd_pkg::mark_bits_t         held_marks = '0;
  int unsigned                  held_count = 0;

  int unsigned mismatches = 0;
  int unsigned transfers_in = 0;
  int unsigned results_seen = 0;
  int unsigned settings_run = 1;
  int unsigned outcome_seen[4];

  function automatic prediction_t decode_key_event(
      input logic kind, input logic [mpgd_pkg::DUR_W-1:0] dur);
    prediction_t p;
    logic        is_dash;
    int unsigned node;
    logic [7:0]  ch;
    p.hit = 1'b0;
    p.res = '0;
    if (kind == KEY_PRESS) begin
      if (dur == 0) return p;
      if (dur < dot_lim) is_dash = 1'b0;
      else if (dur < dash_lim) is_dash = 1'b1;
      else begin
        p.hit = 1'b1;
        p.res.glyph = mpgd_pkg::GLYPH_ERROR;
        p.res.outcome = mpgd_pkg::OUTCOME_LONG;
        return p;
      end
      if (held_count >= mpgd_pkg::MAX_MARKS) begin
        held_marks = '0;
        held_count = 0;
        p.hit = 1'b1;
        p.res.glyph = mpgd_pkg::GLYPH_ERROR;
        p.res.outcome = mpgd_pkg::OUTCOME_OVERFLOW;
        return p;
      end
      held_marks = {held_marks[2:0], is_dash};
      held_count++;
      return p;
    end
    if (dur < gap_lim || held_count == 0) return p;
    node = (1 << held_count) | (held_marks & ((1 << held_count) - 1));
    ch = MORSE_TREE[8*(31-node) +: 8];
    p.hit = 1'b1;
    if (ch == "?") begin
      p.res.glyph = mpgd_pkg::GLYPH_ERROR;
      p.res.outcome = mpgd_pkg::OUTCOME_INVALID;
    end else begin
      p.res.glyph = mpgd_pkg::glyph_t'(ch - "A" + 1);
      p.res.outcome = mpgd_pkg::OUTCOME_LETTER;
    end
    held_marks = '0;
    held_count = 0;
    return p;
  endfunction

  // driver: bursts of transfers separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  key_event_t  drv_event;
  prediction_t drv_pred;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        transfers_in++;
        drv_pred = decode_key_event(s_tuser, s_tdata[mpgd_pkg::DUR_W-1:0]);
        if (drv_pred.hit) decoded_due.push_back(drv_pred.res);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (key_events.size() == 0) begin
          s_tvalid <= 1'b0;
        end else begin
          drv_event = key_events.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= drv_event.kind;
          s_tdata <= {1'b0, drv_event.dur};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
          end
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest expectation
  int unsigned       ready_run = 0;
  int unsigned       ready_mode = 0;
  mpgd_pkg::result_t mon_got;
  mpgd_pkg::result_t mon_due;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got.glyph = m_tdata[mpgd_pkg::GLYPH_W-1:0];
      mon_got.outcome = mpgd_pkg::outcome_t'(m_tuser);
      results_seen++;
      if (decoded_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result glyph %0d outcome %0d", $realtime,
                   mon_got.glyph, mon_got.outcome);
      end else begin
        mon_due = decoded_due.pop_front();
        outcome_seen[mon_due.outcome]++;
        if (mon_got.glyph !== mon_due.glyph ||
            mon_got.outcome !== mon_due.outcome) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: result mismatch: expected glyph %0d outcome %0d, ",
                      "got glyph %0d outcome %0d"},
                     $realtime, mon_due.glyph, mon_due.outcome,
                     mon_got.glyph, mon_got.outcome);
        end
      end
    end
    if (ready_run == 0) begin
      ready_mode = $urandom_range(2, 0);
      ready_run = $urandom_range(300, 40);
    end
    ready_run--;
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(3, 0) != 0);
      default: m_tready <= ($urandom_range(2, 0) == 0);
    endcase
  end

  task automatic push_event(input logic kind, input int unsigned dur);
    key_event_t ev;
    ev.kind = kind;
    ev.dur = dur[mpgd_pkg::DUR_W-1:0];
    key_events.push_back(ev);
  endtask

  task automatic cfg_write(input mpgd_pkg::cfg_index_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mpgd_pkg::CFG_DOT_LIMIT:  dot_lim = value;
      mpgd_pkg::CFG_DASH_LIMIT: dash_lim = value;
      mpgd_pkg::CFG_GAP_LIMIT:  gap_lim = value;
      default: ;
    endcase
  endtask

  // hold until every transfer is out and every result is back
  task automatic drain();
    while (key_events.size() != 0 || s_tvalid || decoded_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_letter();
    int unsigned n;
    int unsigned d;
    n = ($urandom_range(7, 0) == 0) ? 5 : $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      if (dot_lim > 1 && (dash_lim <= dot_lim || $urandom_range(1, 0) == 1))
        d = $urandom_range(dot_lim - 1, 1);
      else if (dash_lim > dot_lim)
        d = $urandom_range(dash_lim - 1, dot_lim);
      else
        d = $urandom_range(DUR_MAX, 1);
      push_event(KEY_PRESS, d);
      if (gap_lim > 0 && $urandom_range(3, 0) == 0)
        push_event(KEY_GAP, $urandom_range(gap_lim - 1, 0));
    end
    if ($urandom_range(7, 0) == 0) d = $urandom_range(DUR_MAX, gap_lim);
    else d = $urandom_range(gap_lim + 40, gap_lim);
    push_event(KEY_GAP, d);
  endtask

  task automatic add_noise();
    int unsigned d;
    int unsigned near_lim;
    case ($urandom_range(3, 0))
      0: d = $urandom_range(DUR_MAX, 0);
      1: d = 0;
      default: begin
        case ($urandom_range(2, 0))
          0: near_lim = dot_lim;
          1: near_lim = dash_lim;
          default: near_lim = gap_lim;
        endcase
        d = near_lim + $urandom_range(2, 0);
        if (d > 0) d = d - 1;
      end
    endcase
    push_event(1'($urandom_range(1, 0)), d);
  endtask

  task automatic random_events(input int unsigned count);
    int unsigned target;
    target = key_events.size() + count;
    while (key_events.size() < target) begin
      if ($urandom_range(3, 0) != 0) add_letter();
      else add_noise();
    end
  endtask

  task automatic run_phase(input logic [15:0] dot, input logic [15:0] dash,
                           input logic [15:0] gap);
    cfg_write(mpgd_pkg::CFG_DOT_LIMIT, dot);
    cfg_write(mpgd_pkg::CFG_DASH_LIMIT, dash);
    cfg_write(mpgd_pkg::CFG_GAP_LIMIT, gap);
    settings_run++;
    random_events(PHASE_EVENTS / 2);
    drain();
    random_events(PHASE_EVENTS / 2);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset limits: dot < 250, dash < 700, gap >= 400
    push_event(KEY_PRESS, 0);
    push_event(KEY_GAP, DUR_MAX);
    push_event(KEY_PRESS, 1);
    push_event(KEY_GAP, 399);
    push_event(KEY_GAP, 400);
    push_event(KEY_PRESS, 249);
    push_event(KEY_PRESS, 250);
    push_event(KEY_PRESS, 700);
    push_event(KEY_PRESS, DUR_MAX);
    push_event(KEY_GAP, DUR_MAX);
    push_event(KEY_PRESS, 699);
    push_event(KEY_GAP, 0);
    push_event(KEY_GAP, 400);
    push_event(KEY_PRESS, 10);
    push_event(KEY_PRESS, 20);
    push_event(KEY_PRESS, 300);
    push_event(KEY_PRESS, 400);
    push_event(KEY_GAP, 500);
    push_event(KEY_PRESS, 300);
    push_event(KEY_PRESS, 1);
    push_event(KEY_PRESS, 699);
    push_event(KEY_PRESS, 400);
    push_event(KEY_PRESS, 100);
    push_event(KEY_GAP, 400);
    drain();
    random_events(PHASE_EVENTS);
    drain();

    run_phase(16'd3, 16'd9, 16'd5);
    run_phase(16'd1, 16'd65535, 16'd0);
    run_phase(16'd65535, 16'd65535, 16'd65535);
    run_phase(16'd800, 16'd300, 16'd1);
    run_phase(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
              16'($urandom_range(65535, 0)));
    run_phase(16'd1, 16'd1, 16'd0);

    repeat (20) @(posedge clk);
    if (decoded_due.size() != 0) begin
      $display("%0d expected results never arrived", decoded_due.size());
      mismatches += decoded_due.size();
    end
    $display("sent %0d key events under %0d limit settings, checked %0d results",
             transfers_in, settings_run, results_seen);
    $display("letters %0d, long presses %0d, overflows %0d, invalid patterns %0d",
             outcome_seen[mpgd_pkg::OUTCOME_LETTER],
             outcome_seen[mpgd_pkg::OUTCOME_LONG],
             outcome_seen[mpgd_pkg::OUTCOME_OVERFLOW],
             outcome_seen[mpgd_pkg::OUTCOME_INVALID]);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", decoded_due.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule
